// ----- hw/rtl/dltq_pkg.sv -----
// Shared types and codes for the delta-list timer queue.
`default_nettype none

package dltq_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;
    localparam int PERIOD_W    = 10;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic        event_kind;
        logic [31:0] delay_ms;
    } t_in_item;

    typedef struct packed {
        logic        fired;
        logic [4:0]  fired_slot;
        logic        fired_event;
        logic        found;
        logic [31:0] remaining_ticks;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_UL,
        S_UL_FIX,
        S_INS,
        S_INS_W2,
        S_INS_W3,
        S_TK_HEAD,
        S_TK_NEXT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/delta_list_timer_queue.sv -----
// Delta-list timer queue: entry table in one memory, list walks by a sequencer.
// Each transaction is accepted in the idle state; its result goes into the output register.
//   Insert divides the delay by the tick period, unlinks the entry if it is queued, walks
//   the list and links the entry in. Remove walks to the entry and fixes up any follower.
// A tick on an empty list gives an empty result; else it decrements the head or fires expiries.
// One transaction is in work at a time, and a stalled result holds it. Reset (synchronous,
//   active low) empties the list and sets the period to 10 ms; the memory is not cleared.
`default_nettype none

module delta_list_timer_queue #(
    parameter int SLOTS       = 32,
    parameter int EVENT_KINDS = 2
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [dltq_pkg::PERIOD_W-1:0] i_cfg_wdata,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire dltq_pkg::t_in_item    i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output dltq_pkg::t_out_item        o_out_data
);

    // Table geometry. The index value ENTRIES serves as the null link.
    localparam int ENTRIES = SLOTS * EVENT_KINDS;
    localparam int IW      = $clog2(ENTRIES + 1);
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WW      = IW + 32;
    localparam logic [IW-1:0] NIL = IW'(ENTRIES);

    // Saturating add of two tick counts.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Entry memory: each word holds {next link, delta ticks}. One write port and
    // one registered read port; a write to the address being read is forwarded.
    logic [WW-1:0] mem [ENTRIES];
    logic [WW-1:0] r_rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [WW-1:0] wr_data;
    logic [IW-1:0] rd_next;
    logic [31:0]   rd_delta;

    // Sequencer state. Unless r_it is the null link, it names the entry whose word sits in r_rd_data.
    dltq_pkg::t_state r_state, n_state;
    logic [IW-1:0]      r_head, n_head;
    logic [ENTRIES-1:0] r_queued, n_queued;
    logic [IW-1:0]      r_it, n_it;
    logic [IW-1:0]      r_prev, n_prev;
    logic [31:0]        r_prev_delta, n_prev_delta;
    logic [IW-1:0]      r_e, n_e;
    logic               r_mode_ins, n_mode_ins;
    logic [31:0]        r_ticks, n_ticks;
    logic [31:0]        r_sum, n_sum;
    logic [31:0]        r_de, n_de;
    logic [WW-1:0]      r_it_word, n_it_word;
    logic [9:0]         r_rem, n_rem;
    logic [31:0]        r_quo, n_quo;
    logic [dltq_pkg::PERIOD_W-1:0] r_per, n_per;
    logic [4:0]         r_dcnt, n_dcnt;
    logic [dltq_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [IW-1:0]      r_fh, n_fh;
    dltq_pkg::t_out_item r_res, n_res;
    logic                r_out_valid, n_out_valid;
    dltq_pkg::t_out_item r_out_data, n_out_data;
    logic [dltq_pkg::PERIOD_W-1:0] r_period;

    // Decoded input and scratch values.
    logic          out_free;
    logic [8:0]    e_wide;
    logic [IW-1:0] e_in;
    logic          valid_in;
    logic [10:0]   div_t;
    logic          div_ge;
    logic [10:0]   div_diff;
    logic [31:0]   left;
    logic          fire_last;
    dltq_pkg::t_out_item zero_res;

    assign rd_next  = r_rd_data[WW-1:32];
    assign rd_delta = r_rd_data[31:0];
    assign out_free = !r_out_valid || i_out_ready;
    assign e_wide   = 9'(i_in_data.slot) * 9'(EVENT_KINDS) + 9'(i_in_data.event_kind);
    assign e_in     = e_wide[IW-1:0];
    assign valid_in = ({2'b00, i_in_data.slot} < 7'(SLOTS))
                   && ({2'b00, i_in_data.event_kind} < 3'(EVENT_KINDS));
    assign div_t    = {r_rem, r_quo[31]};
    assign div_ge   = div_t >= {1'b0, r_per};
    assign div_diff = div_t - {1'b0, r_per};
    assign left     = sat_add(r_sum, rd_delta);
    assign fire_last = (r_it == NIL) || (rd_delta != 32'd0)
                    || (r_cnt == dltq_pkg::CNT_W'(dltq_pkg::MAX_RESULTS));

    always_comb begin
        zero_res      = '0;
        zero_res.last = 1'b1;
    end

    assign o_in_ready  = (r_state == dltq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_queued     = r_queued;
        n_it         = r_it;
        n_prev       = r_prev;
        n_prev_delta = r_prev_delta;
        n_e          = r_e;
        n_mode_ins   = r_mode_ins;
        n_ticks      = r_ticks;
        n_sum        = r_sum;
        n_de         = r_de;
        n_it_word    = r_it_word;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_per        = r_per;
        n_dcnt       = r_dcnt;
        n_cnt        = r_cnt;
        n_fh         = r_fh;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        wr_en        = 1'b0;
        wr_addr      = r_it;
        wr_data      = r_rd_data;

        unique case (r_state)
            dltq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_res = zero_res;
                    n_e   = e_in;
                    unique case (i_in_data.kind)
                        dltq_pkg::KIND_INSERT: begin
                            if (valid_in) begin
                                n_quo   = i_in_data.delay_ms;
                                n_rem   = '0;
                                n_per   = (r_period == '0) ? dltq_pkg::PERIOD_W'(1) : r_period;
                                n_dcnt  = '0;
                                n_state = dltq_pkg::S_DIV;
                            end else begin
                                n_state = dltq_pkg::S_EMIT;
                            end
                        end
                        dltq_pkg::KIND_REMOVE: begin
                            if (valid_in && r_queued[e_in[AW-1:0]]) begin
                                n_mode_ins = 1'b0;
                                n_it       = r_head;
                                n_prev     = NIL;
                                n_sum      = '0;
                                n_state    = dltq_pkg::S_UL;
                            end else begin
                                n_state = dltq_pkg::S_EMIT;
                            end
                        end
                        dltq_pkg::KIND_TICK: begin
                            if (r_head != NIL) begin
                                n_it    = r_head;
                                n_state = dltq_pkg::S_TK_HEAD;
                            end else begin
                                n_state = dltq_pkg::S_EMIT;
                            end
                        end
                        default: n_state = dltq_pkg::S_EMIT;
                    endcase
                end
            end

            // Restoring division, one quotient bit per cycle.
            dltq_pkg::S_DIV: begin
                n_rem  = div_ge ? div_diff[9:0] : div_t[9:0];
                n_quo  = {r_quo[30:0], div_ge};
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_ticks = n_quo + {31'd0, (n_rem != 10'd0)};
                    n_prev  = NIL;
                    n_it    = r_head;
                    n_sum   = '0;
                    if (r_queued[r_e[AW-1:0]]) begin
                        n_mode_ins = 1'b1;
                        n_state    = dltq_pkg::S_UL;
                    end else begin
                        n_state = dltq_pkg::S_INS;
                    end
                end
            end

            // Walk to the entry being unlinked, summing deltas on the way.
            dltq_pkg::S_UL: begin
                if (r_it == r_e) begin
                    n_sum = left;
                    n_de  = rd_delta;
                    n_queued[r_e[AW-1:0]] = 1'b0;
                    if (r_prev == NIL) begin
                        n_head = rd_next;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_prev;
                        wr_data = {rd_next, r_prev_delta};
                    end
                    if (rd_next != NIL) begin
                        n_it    = rd_next;
                        n_state = dltq_pkg::S_UL_FIX;
                    end else if (r_mode_ins) begin
                        n_it    = n_head;
                        n_prev  = NIL;
                        n_state = dltq_pkg::S_INS;
                    end else begin
                        n_res.found           = 1'b1;
                        n_res.remaining_ticks = left;
                        n_state               = dltq_pkg::S_EMIT;
                    end
                end else begin
                    n_sum        = left;
                    n_prev       = r_it;
                    n_prev_delta = rd_delta;
                    n_it         = rd_next;
                end
            end

            // The follower takes over the removed delta.
            dltq_pkg::S_UL_FIX: begin
                wr_en   = 1'b1;
                wr_addr = r_it;
                wr_data = {rd_next, sat_add(rd_delta, r_de)};
                if (r_mode_ins) begin
                    n_it    = r_head;
                    n_prev  = NIL;
                    n_state = dltq_pkg::S_INS;
                end else begin
                    n_res.found           = 1'b1;
                    n_res.remaining_ticks = r_sum;
                    n_state               = dltq_pkg::S_EMIT;
                end
            end

            // Walk to the insertion point, then link the entry in.
            dltq_pkg::S_INS: begin
                if ((r_it == NIL) || (r_ticks <= rd_delta)) begin
                    n_it_word = r_rd_data;
                    n_queued[r_e[AW-1:0]] = 1'b1;
                    if (r_prev == NIL) begin
                        n_head = r_e;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_prev;
                        wr_data = {r_e, r_prev_delta};
                    end
                    n_state = dltq_pkg::S_INS_W2;
                end else begin
                    n_ticks      = r_ticks - rd_delta;
                    n_prev       = r_it;
                    n_prev_delta = rd_delta;
                    n_it         = rd_next;
                end
            end

            dltq_pkg::S_INS_W2: begin
                wr_en   = 1'b1;
                wr_addr = r_e;
                wr_data = {r_it, r_ticks};
                n_state = (r_it != NIL) ? dltq_pkg::S_INS_W3 : dltq_pkg::S_EMIT;
            end

            dltq_pkg::S_INS_W3: begin
                wr_en   = 1'b1;
                wr_addr = r_it;
                wr_data = {r_it_word[WW-1:32], r_it_word[31:0] - r_ticks};
                n_state = dltq_pkg::S_EMIT;
            end

            // Decrement the head, or start firing if it reaches zero.
            dltq_pkg::S_TK_HEAD: begin
                if (rd_delta > 32'd1) begin
                    wr_en   = 1'b1;
                    wr_addr = r_it;
                    wr_data = {rd_next, rd_delta - 32'd1};
                    n_state = dltq_pkg::S_EMIT;
                end else begin
                    n_fh    = r_it;
                    n_head  = rd_next;
                    n_queued[r_it[AW-1:0]] = 1'b0;
                    n_cnt   = dltq_pkg::CNT_W'(1);
                    n_it    = rd_next;
                    n_state = dltq_pkg::S_TK_NEXT;
                end
            end

            // The new head, or the per-tick result limit, decides whether the pending expiry is the last one.
            dltq_pkg::S_TK_NEXT: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_data                 = '0;
                    n_out_data.fired           = 1'b1;
                    n_out_data.fired_slot      = 5'(r_fh / EVENT_KINDS);
                    n_out_data.fired_event     = 1'(r_fh % EVENT_KINDS);
                    n_out_data.last            = fire_last;
                    if (fire_last) begin
                        n_state = dltq_pkg::S_IDLE;
                    end else begin
                        n_fh   = r_it;
                        n_head = rd_next;
                        n_queued[r_it[AW-1:0]] = 1'b0;
                        n_cnt  = r_cnt + dltq_pkg::CNT_W'(1);
                        n_it   = rd_next;
                    end
                end
            end

            dltq_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = dltq_pkg::S_IDLE;
                end
            end

            default: n_state = dltq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (n_it != NIL) begin
            r_rd_data <= (wr_en && (wr_addr == n_it)) ? wr_data : mem[n_it[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dltq_pkg::S_IDLE;
            r_head      <= NIL;
            r_queued    <= '0;
            r_out_valid <= 1'b0;
            r_period    <= dltq_pkg::PERIOD_RESET;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_queued    <= n_queued;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_it         <= n_it;
        r_prev       <= n_prev;
        r_prev_delta <= n_prev_delta;
        r_e          <= n_e;
        r_mode_ins   <= n_mode_ins;
        r_ticks      <= n_ticks;
        r_sum        <= n_sum;
        r_de         <= n_de;
        r_it_word    <= n_it_word;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_per        <= n_per;
        r_dcnt       <= n_dcnt;
        r_cnt        <= n_cnt;
        r_fh         <= n_fh;
        r_res        <= n_res;
        r_out_data   <= n_out_data;
    end

    // An empty list between transactions means no entry is marked queued.
    a_empty_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dltq_pkg::S_IDLE && r_head == NIL) |-> (r_queued == '0))
        else $error("empty list with queued entries");

    // The expiry chain never exceeds the per-tick result limit.
    a_fire_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dltq_pkg::S_TK_NEXT) |->
            (r_cnt != '0 && r_cnt <= dltq_pkg::CNT_W'(dltq_pkg::MAX_RESULTS)))
        else $error("expiry count out of range");

    // An expiry result carries no remove status.
    a_fire_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.fired) |->
            (!r_out_data.found && r_out_data.remaining_ticks == 32'd0))
        else $error("expiry result carries remove fields");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dltq_pkg::S_DIV) |-> (r_per != '0))
        else $error("zero tick period in divider");

endmodule

`default_nettype wire

// ----- tb/sv/delta_list_timer_queue_tb.sv -----
// Testbench for the delta-list timer queue: directed and random insert, remove and tick traffic.
`default_nettype none

module delta_list_timer_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 64;
    localparam int NIL     = ENTRIES;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [dltq_pkg::PERIOD_W-1:0] i_cfg_wdata = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    dltq_pkg::t_in_item            i_in_data = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    dltq_pkg::t_out_item           o_out_data;

    delta_list_timer_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the timer table kept by the predictor.
    logic [dltq_pkg::PERIOD_W-1:0] period_ms;
    logic [31:0]         delta_tbl [ENTRIES];
    int                  next_tbl  [ENTRIES];
    bit                  queued_tbl[ENTRIES];
    int                  head_idx;

    dltq_pkg::t_out_item expected_results[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // Unlinks an entry if queued and returns the ticks it had left, saturated.
    function automatic bit unlink_timer(int e, output logic [31:0] left);
        longint unsigned sum;
        longint unsigned d;
        int prev;
        int it;
        sum = 0;
        prev = NIL;
        it = head_idx;
        left = '0;
        while (it != NIL && it != e) begin
            sum += delta_tbl[it];
            prev = it;
            it = next_tbl[it];
        end
        if (it == NIL) return 1'b0;
        sum += delta_tbl[e];
        if (prev == NIL) head_idx = next_tbl[e];
        else next_tbl[prev] = next_tbl[e];
        if (next_tbl[e] != NIL) begin
            d = longint'(delta_tbl[next_tbl[e]]) + delta_tbl[e];
            delta_tbl[next_tbl[e]] = (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
        end
        queued_tbl[e] = 1'b0;
        left = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        return 1'b1;
    endfunction

    function automatic void insert_timer(int e, logic [31:0] ms);
        logic [31:0] per;
        logic [31:0] ticks;
        logic [31:0] unused_left;
        int prev;
        int it;
        per = (period_ms == 0) ? 32'd1 : 32'(period_ms);
        ticks = ms / per + ((ms % per) != 0 ? 32'd1 : 32'd0);
        if (queued_tbl[e]) void'(unlink_timer(e, unused_left));
        prev = NIL;
        it = head_idx;
        while (it != NIL && ticks > delta_tbl[it]) begin
            ticks -= delta_tbl[it];
            prev = it;
            it = next_tbl[it];
        end
        if (prev == NIL) head_idx = e;
        else next_tbl[prev] = e;
        next_tbl[e] = it;
        if (it != NIL) delta_tbl[it] -= ticks;
        delta_tbl[e] = ticks;
        queued_tbl[e] = 1'b1;
    endfunction

    // Computes the results one transaction causes and queues them.
    function automatic void predict_timer_results(dltq_pkg::t_in_item it_in);
        dltq_pkg::t_out_item r;
        int e;
        int n;
        logic [31:0] left;
        bit f;
        e = int'(it_in.slot) * 2 + int'(it_in.event_kind);
        r = '0;
        r.last = 1'b1;
        if (it_in.kind == dltq_pkg::KIND_INSERT) begin
            insert_timer(e, it_in.delay_ms);
            expected_results.push_back(r);
        end else if (it_in.kind == dltq_pkg::KIND_REMOVE) begin
            f = queued_tbl[e] && unlink_timer(e, left);
            r.found = f;
            r.remaining_ticks = f ? left : '0;
            expected_results.push_back(r);
        end else if (it_in.kind == dltq_pkg::KIND_TICK) begin
            n = 0;
            if (head_idx != NIL && delta_tbl[head_idx] > 0) delta_tbl[head_idx]--;
            while (head_idx != NIL && delta_tbl[head_idx] == 0
                   && n < dltq_pkg::MAX_RESULTS) begin
                r = '0;
                r.fired = 1'b1;
                r.fired_slot = 5'(head_idx / 2);
                r.fired_event = head_idx[0];
                queued_tbl[head_idx] = 1'b0;
                head_idx = next_tbl[head_idx];
                expected_results.push_back(r);
                n++;
            end
            if (n == 0) begin
                r = '0;
                r.last = 1'b1;
                expected_results.push_back(r);
            end else begin
                expected_results[$].last = 1'b1;
            end
        end else begin
            // The unused kind code gives a single empty result.
            expected_results.push_back(r);
        end
    endfunction

    // Sends one transaction, holding valid and the payload until it is accepted.
    // Valid stays high afterwards unless the next call idles or the bench drains.
    task automatic send_item(dltq_pkg::t_in_item it_in);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it_in;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_timer_results(it_in);
    endtask

    function automatic dltq_pkg::t_in_item make_item(logic [1:0] k, int e, logic [31:0] ms);
        dltq_pkg::t_in_item it_in;
        it_in.kind = k;
        it_in.slot = 5'(e / 2);
        it_in.event_kind = e[0];
        it_in.delay_ms = ms;
        return it_in;
    endfunction

    // The receiver stalls at random and checks every accepted result in order.
    always @(posedge i_clk) begin
        dltq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result %p", o_out_data);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result mismatch: expected %p, got %p", want, o_out_data);
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Stops sending, waits for every expected result, then lets the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_tick_period(logic [dltq_pkg::PERIOD_W-1:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        period_ms = v;
    endtask

    // Extremes of the fields, each operation and each named special case.
    task automatic test_directed();
        dltq_pkg::t_in_item it_in;
        send_item(make_item(dltq_pkg::KIND_TICK, 0, 0));     // tick on an empty list
        send_item(make_item(dltq_pkg::KIND_REMOVE, 63, 0));  // remove of an unqueued entry
        send_item(make_item(dltq_pkg::KIND_INSERT, 0, 0));   // zero delay fires next tick
        send_item(make_item(dltq_pkg::KIND_INSERT, 63, 32'hFFFF_FFFF));
        send_item(make_item(dltq_pkg::KIND_INSERT, 5, 25));  // rounds up to three ticks
        send_item(make_item(dltq_pkg::KIND_INSERT, 6, 30));  // same time, goes before entry five
        send_item(make_item(dltq_pkg::KIND_INSERT, 5, 11));  // re-insert of a queued entry
        send_item(make_item(dltq_pkg::KIND_REMOVE, 6, 0));
        send_item(make_item(dltq_pkg::KIND_TICK, 0, 0));
        send_item(make_item(dltq_pkg::KIND_TICK, 0, 0));
        send_item(make_item(dltq_pkg::KIND_TICK, 0, 0));
        send_item(make_item(dltq_pkg::KIND_REMOVE, 63, 0));
        it_in = make_item(dltq_pkg::KIND_UNUSED, 62, 32'h5555_AAAA);
        send_item(it_in);
        // Every entry at zero delay: one tick fires all sixty-four.
        for (int e = 0; e < ENTRIES; e++) send_item(make_item(dltq_pkg::KIND_INSERT, e, 0));
        send_item(make_item(dltq_pkg::KIND_TICK, 0, 0));
        send_item(make_item(dltq_pkg::KIND_TICK, 0, 0));
    endtask

    // Well-formed traffic with random content, with some noise mixed in.
    task automatic test_random(int count);
        logic [31:0] ms;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            case ($urandom_range(3))
                0: ms = $urandom();
                1: ms = $urandom_range(64);
                default: ms = $urandom_range(period_ms * 8 + 8);
            endcase
            if (pick < 40)
                send_item(make_item(dltq_pkg::KIND_INSERT, $urandom_range(63), ms));
            else if (pick < 60)
                send_item(make_item(dltq_pkg::KIND_REMOVE, $urandom_range(63), ms));
            else if (pick < 97)
                send_item(make_item(dltq_pkg::KIND_TICK, $urandom_range(63), ms));
            else
                send_item(make_item(dltq_pkg::KIND_UNUSED, $urandom_range(63), ms));
        end
    endtask

    task automatic test_tick_periods();
        write_tick_period(10'd0);          // zero period counts as one millisecond
        test_random(40);
        write_tick_period(10'd1);
        test_random(40);
        write_tick_period(10'd1023);
        test_random(40);
        write_tick_period(dltq_pkg::PERIOD_RESET);
    endtask

    initial begin
        period_ms = dltq_pkg::PERIOD_RESET;
        head_idx  = NIL;
        for (int e = 0; e < ENTRIES; e++) queued_tbl[e] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 69;
        test_directed();
        test_random(80);
        send_idle_pct = 69;
        recv_idle_pct = 22;
        test_tick_periods();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(40);

        drain_results();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Generous cap on the whole run.
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
